// ===== sv/mlpq_pkg.sv =====
// shared types and codes for the multi-level priority queue
`default_nettype none
package mlpq_pkg;

  localparam int ID_W = 16;
  localparam int PR_W = 3;
  localparam int TC_W = 8;
  localparam int LC_W = 5;
  localparam int ST_W = 2;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] K_ENQ  = 2'd0;
  localparam logic [1:0] K_DEQ  = 2'd1;
  localparam logic [1:0] K_PEEK = 2'd2;
  localparam logic [1:0] K_BAD  = 2'd3;

  localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
  localparam logic [ST_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [ST_W-1:0] STAT_BADPR = 2'd2;
  localparam logic [ST_W-1:0] STAT_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] task_id;
    logic [PR_W-1:0] pr;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0] head_task;
    logic [PR_W-1:0] head_priority;
    logic            head_valid;
    logic [TC_W-1:0] total_count;
    logic [LC_W-1:0] level_count;
    logic            is_empty;
    logic [ST_W-1:0] status;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/mlpq_ram.sv =====
// generic single-write, single-read ram with registered read
`default_nettype none
module mlpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/mlpq_front.sv =====
// input side: accepts words, classifies them and queues them for the back end
`default_nettype none
module mlpq_front #(
  parameter int LEVELS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [1:0]                     in_op,
  input  wire logic [mlpq_pkg::ID_W-1:0]      in_task_id,
  input  wire logic [mlpq_pkg::PR_W-1:0]      in_priority_req,
  input  wire logic [mlpq_pkg::PR_W-1:0]      top_level,
  output logic                                cmd_valid,
  output mlpq_pkg::cmd_t                      cmd,
  input  wire logic                           cmd_take
);

  mlpq_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;
  mlpq_pkg::cmd_t cls;

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_push && !in_full;
  assign pop       = cmd_take && cmd_valid;

  always_comb begin
    cls.task_id = in_task_id;
    cls.pr      = in_priority_req;
    case (in_op)
      mlpq_pkg::OP_ENQ: begin
        if ((in_priority_req > top_level) || (7'(in_priority_req) >= 7'(LEVELS))) begin
          cls.kind = mlpq_pkg::K_BAD;
        end else begin
          cls.kind = mlpq_pkg::K_ENQ;
        end
      end
      mlpq_pkg::OP_DEQ: cls.kind = mlpq_pkg::K_DEQ;
      default:          cls.kind = mlpq_pkg::K_PEEK;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mlpq_back.sv =====
// back end: level pointers and counts, task ram and the result queue
`default_nettype none
module mlpq_back #(
  parameter int LEVELS  = 8,
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [mlpq_pkg::PR_W-1:0] top_level,
  input  wire logic                      cmd_valid,
  input  wire mlpq_pkg::cmd_t            cmd,
  output logic                           cmd_take,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output mlpq_pkg::res_t                 out_res
);

  localparam int NL = (LEVELS < 8) ? LEVELS : 8;
  localparam int LW = $clog2(NL);
  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int SW = (ID_BITS < 16) ? ID_BITS : 16;
  localparam int RD = NL * DEPTH;
  localparam int AW = $clog2(RD);

  localparam logic S_EXEC   = 1'b0;
  localparam logic S_RESULT = 1'b1;

  logic          state_r, state_nxt;
  logic [PW-1:0] head_ptr_r [NL];
  logic [PW-1:0] head_ptr_nxt [NL];
  logic [PW-1:0] tail_ptr_r [NL];
  logic [PW-1:0] tail_ptr_nxt [NL];
  logic [FW-1:0] fill_r [NL];
  logic [FW-1:0] fill_nxt [NL];

  logic                      hv_r;
  logic [LW-1:0]             hl_r;
  logic                      byp_r;
  logic [SW-1:0]             byp_tid_r;
  logic [mlpq_pkg::ST_W-1:0] stat_r;
  logic [mlpq_pkg::PR_W-1:0] pr_r;

  mlpq_pkg::res_t oq_r [2];
  logic           oq_wr_r, oq_rd_r;
  logic [1:0]     oq_cnt_r, oq_cnt_nxt;
  logic           oq_push, oq_pop;

  logic [LW-1:0]             lp;
  logic                      go;
  logic [NL-1:0]             nz_pre, nz_post, vec;
  logic                      full_lp, enq_ok, deq_ok, is_deq;
  logic                      hf;
  logic [LW-1:0]             hl;
  logic [mlpq_pkg::ST_W-1:0] stat;
  logic                      byp;
  logic [AW-1:0]             raddr, waddr;
  logic                      we;
  logic [SW-1:0]             rdata;

  mlpq_pkg::res_t            res;
  logic [mlpq_pkg::TC_W-1:0] vis_total;
  logic                      any_vis;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign lp       = cmd.pr[LW-1:0];
  assign go       = (state_r == S_EXEC) && cmd_valid && (oq_cnt_r != 2'd2);
  assign cmd_take = go;
  assign is_deq   = (cmd.kind == mlpq_pkg::K_DEQ);
  assign full_lp  = (fill_r[lp] == FW'(DEPTH));
  assign enq_ok   = (cmd.kind == mlpq_pkg::K_ENQ) && !full_lp;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      nz_pre[l]  = (fill_r[l] != '0) && (l <= int'(top_level));
      nz_post[l] = nz_pre[l] || (enq_ok && (lp == LW'(l)));
    end
    vec = is_deq ? nz_pre : nz_post;
    hf  = 1'b0;
    hl  = '0;
    for (int l = 0; l < NL; l++) begin
      if (vec[l]) begin
        hf = 1'b1;
        hl = LW'(l);
      end
    end
  end

  assign deq_ok = is_deq && hf;
  assign byp    = enq_ok && (hl == lp) && (fill_r[lp] == '0);
  assign raddr  = AW'(hl) * AW'(DEPTH) + AW'(head_ptr_r[hl]);
  assign waddr  = AW'(lp) * AW'(DEPTH) + AW'(tail_ptr_r[lp]);
  assign we     = go && enq_ok;

  always_comb begin
    case (cmd.kind)
      mlpq_pkg::K_ENQ: stat = full_lp ? mlpq_pkg::STAT_FULL : mlpq_pkg::STAT_OK;
      mlpq_pkg::K_BAD: stat = mlpq_pkg::STAT_BADPR;
      mlpq_pkg::K_DEQ: stat = hf ? mlpq_pkg::STAT_OK : mlpq_pkg::STAT_EMPTY;
      default:         stat = mlpq_pkg::STAT_OK;
    endcase
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      head_ptr_nxt[l] = head_ptr_r[l];
      tail_ptr_nxt[l] = tail_ptr_r[l];
      fill_nxt[l]     = fill_r[l];
      if (go && enq_ok && (lp == LW'(l))) begin
        tail_ptr_nxt[l] = ptr_inc(tail_ptr_r[l]);
        fill_nxt[l]     = fill_r[l] + FW'(1);
      end
      if (go && deq_ok && (hl == LW'(l))) begin
        head_ptr_nxt[l] = ptr_inc(head_ptr_r[l]);
        fill_nxt[l]     = fill_r[l] - FW'(1);
      end
    end
    state_nxt = state_r;
    case (state_r)
      S_EXEC:   state_nxt = go ? S_RESULT : S_EXEC;
      S_RESULT: state_nxt = S_EXEC;
      default:  state_nxt = S_EXEC;
    endcase
  end

  mlpq_ram #(
    .WIDTH (SW),
    .DEPTH (RD)
  ) u_task_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cmd.task_id[SW-1:0]),
    .re    (go),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (go) begin
      hv_r      <= hf;
      hl_r      <= hl;
      byp_r     <= byp;
      byp_tid_r <= cmd.task_id[SW-1:0];
      stat_r    <= stat;
      pr_r      <= cmd.pr;
    end
  end

  // result assembled from the updated counts
  always_comb begin
    vis_total = '0;
    any_vis   = 1'b0;
    for (int l = 0; l < NL; l++) begin
      if (l <= int'(top_level)) begin
        vis_total = vis_total + mlpq_pkg::TC_W'(fill_r[l]);
        any_vis   = any_vis || (fill_r[l] != '0);
      end
    end
    res.head_task     = hv_r ? (byp_r ? 16'(byp_tid_r) : 16'(rdata)) : '0;
    res.head_priority = hv_r ? mlpq_pkg::PR_W'(hl_r) : '0;
    res.head_valid    = hv_r;
    res.total_count   = vis_total;
    res.level_count   = (4'(pr_r) < 4'(NL)) ?
                        mlpq_pkg::LC_W'(fill_r[pr_r[LW-1:0]]) : '0;
    res.is_empty      = !any_vis;
    res.status        = stat_r;
  end

  assign oq_push   = (state_r == S_RESULT);
  assign out_empty = (oq_cnt_r == 2'd0);
  assign oq_pop    = out_pop && !out_empty;
  assign out_res   = oq_r[oq_rd_r];

  always_comb begin
    case ({oq_push, oq_pop})
      2'b10:   oq_cnt_nxt = oq_cnt_r + 2'd1;
      2'b01:   oq_cnt_nxt = oq_cnt_r - 2'd1;
      default: oq_cnt_nxt = oq_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_EXEC;
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
      for (int l = 0; l < NL; l++) begin
        head_ptr_r[l] <= '0;
        tail_ptr_r[l] <= '0;
        fill_r[l]     <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      oq_wr_r  <= oq_push ? !oq_wr_r : oq_wr_r;
      oq_rd_r  <= oq_pop ? !oq_rd_r : oq_rd_r;
      oq_cnt_r <= oq_cnt_nxt;
      for (int l = 0; l < NL; l++) begin
        head_ptr_r[l] <= head_ptr_nxt[l];
        tail_ptr_r[l] <= tail_ptr_nxt[l];
        fill_r[l]     <= fill_nxt[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= res;
    end
  end

endmodule
`default_nettype wire

// ===== sv/multi_level_priority_queue.sv =====
// top level of the multi-level priority queue
// path: a pushed word waits in the front queue and is taken by the back end in the execute
//   step; the task ram read and the result fields are registered, and the result step writes
//   the result queue; no new word is taken in the result step or while that queue is full
// reset: level pointers and counts cleared, top_level set to 7; the task ram
//   is not cleared, its read data is only used from entries that were written
`default_nettype none
module multi_level_priority_queue #(
  parameter int LEVELS  = 8,
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire logic [1:0]                in_op,
  input  wire logic [mlpq_pkg::ID_W-1:0] in_task_id,
  input  wire logic [mlpq_pkg::PR_W-1:0] in_priority_req,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output logic [mlpq_pkg::ID_W-1:0]      out_head_task,
  output logic [mlpq_pkg::PR_W-1:0]      out_head_priority,
  output logic                           out_head_valid,
  output logic [mlpq_pkg::TC_W-1:0]      out_total_count,
  output logic [mlpq_pkg::LC_W-1:0]      out_level_count,
  output logic                           out_is_empty,
  output logic [mlpq_pkg::ST_W-1:0]      out_status,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [mlpq_pkg::PR_W-1:0] cfg_top_level
);

  logic [mlpq_pkg::PR_W-1:0] top_level_r;
  logic                      cmd_valid;
  logic                      cmd_take;
  mlpq_pkg::cmd_t            cmd;
  mlpq_pkg::res_t            res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_level_r <= 3'd7;
    end else if (cfg_valid && cfg_ready) begin
      top_level_r <= cfg_top_level;
    end
  end

  mlpq_front #(
    .LEVELS (LEVELS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_op           (in_op),
    .in_task_id      (in_task_id),
    .in_priority_req (in_priority_req),
    .top_level       (top_level_r),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_take        (cmd_take)
  );

  mlpq_back #(
    .LEVELS  (LEVELS),
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .top_level (top_level_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res)
  );

  assign out_head_task     = res.head_task;
  assign out_head_priority = res.head_priority;
  assign out_head_valid    = res.head_valid;
  assign out_total_count   = res.total_count;
  assign out_level_count   = res.level_count;
  assign out_is_empty      = res.is_empty;
  assign out_status        = res.status;

endmodule
`default_nettype wire

// ===== tb/multi_level_priority_queue_test.sv =====
// testbench for the multi-level priority queue: random traffic checked against a scoreboard
`timescale 1ns / 100ps
module multi_level_priority_queue_test;

  localparam int LEVELS = 8;
  localparam int DEPTH = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class queue_scoreboard;
    logic [mlpq_pkg::ID_W-1:0] slots [LEVELS][DEPTH];
    logic [3:0] rd_ptr [LEVELS];
    logic [3:0] wr_ptr [LEVELS];
    logic [4:0] fill [LEVELS];
    logic [mlpq_pkg::PR_W-1:0] top_lvl;
    mlpq_pkg::res_t want [$];
    int errors;

    function new();
      for (int lv = 0; lv < LEVELS; lv++) begin
        rd_ptr[lv] = '0;
        wr_ptr[lv] = '0;
        fill[lv] = '0;
      end
      top_lvl = 3'd7;
      errors = 0;
    endfunction

    function void set_top(logic [mlpq_pkg::PR_W-1:0] v);
      top_lvl = v;
    endfunction

    function int pending();
      return want.size();
    endfunction

    function int highest_level();
      for (int lv = int'(top_lvl); lv >= 0; lv--)
        if (fill[lv] != 0) return lv;
      return -1;
    endfunction

    function void note_input(logic [1:0] op, logic [mlpq_pkg::ID_W-1:0] tid,
                             logic [mlpq_pkg::PR_W-1:0] pr);
      mlpq_pkg::res_t r;
      int lv;
      int sum;
      r = '0;
      r.status = mlpq_pkg::STAT_OK;
      if (op == mlpq_pkg::OP_ENQ) begin
        if (pr > top_lvl) begin
          r.status = mlpq_pkg::STAT_BADPR;
        end else if (fill[pr] == 5'(DEPTH)) begin
          r.status = mlpq_pkg::STAT_FULL;
        end else begin
          slots[pr][wr_ptr[pr]] = tid;
          wr_ptr[pr] = wr_ptr[pr] + 4'd1;
          fill[pr] = fill[pr] + 5'd1;
        end
      end else if (op == mlpq_pkg::OP_DEQ) begin
        lv = highest_level();
        if (lv < 0) begin
          r.status = mlpq_pkg::STAT_EMPTY;
        end else begin
          r.head_task = slots[lv][rd_ptr[lv]];
          r.head_priority = 3'(lv);
          r.head_valid = 1'b1;
          rd_ptr[lv] = rd_ptr[lv] + 4'd1;
          fill[lv] = fill[lv] - 5'd1;
        end
      end
      if (op != mlpq_pkg::OP_DEQ) begin
        lv = highest_level();
        if (lv >= 0) begin
          r.head_task = slots[lv][rd_ptr[lv]];
          r.head_priority = 3'(lv);
          r.head_valid = 1'b1;
        end
      end
      r.level_count = fill[pr];
      sum = 0;
      for (int i = 0; i <= int'(top_lvl); i++) sum += int'(fill[i]);
      r.total_count = 8'(sum);
      r.is_empty = (sum == 0);
      want.push_back(r);
    endfunction

    function void compare(string name, logic [mlpq_pkg::ID_W-1:0] exp_v,
                          logic [mlpq_pkg::ID_W-1:0] got_v);
      if (exp_v !== got_v) begin
        $display("%0t: %s mismatch, expected %0h got %0h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(mlpq_pkg::res_t got);
      mlpq_pkg::res_t r;
      if (want.size() == 0) begin
        $display("%0t: unexpected result word, got %0h", $time, got);
        errors++;
        return;
      end
      r = want.pop_front();
      compare("head_task", r.head_task, got.head_task);
      compare("head_priority", 16'(r.head_priority), 16'(got.head_priority));
      compare("head_valid", 16'(r.head_valid), 16'(got.head_valid));
      compare("total_count", 16'(r.total_count), 16'(got.total_count));
      compare("level_count", 16'(r.level_count), 16'(got.level_count));
      compare("is_empty", 16'(r.is_empty), 16'(got.is_empty));
      compare("status", 16'(r.status), 16'(got.status));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic [1:0] in_op;
  logic [mlpq_pkg::ID_W-1:0] in_task_id;
  logic [mlpq_pkg::PR_W-1:0] in_priority_req;
  logic out_empty;
  logic out_pop;
  logic [mlpq_pkg::ID_W-1:0] out_head_task;
  logic [mlpq_pkg::PR_W-1:0] out_head_priority;
  logic out_head_valid;
  logic [mlpq_pkg::TC_W-1:0] out_total_count;
  logic [mlpq_pkg::LC_W-1:0] out_level_count;
  logic out_is_empty;
  logic [mlpq_pkg::ST_W-1:0] out_status;
  logic cfg_valid;
  logic cfg_ready;
  logic [mlpq_pkg::PR_W-1:0] cfg_top_level;

  queue_scoreboard sb;
  bit send_quiet;
  bit recv_quiet;
  mlpq_pkg::res_t got_word;

  multi_level_priority_queue uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_op(in_op),
    .in_task_id(in_task_id),
    .in_priority_req(in_priority_req),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_head_task(out_head_task),
    .out_head_priority(out_head_priority),
    .out_head_valid(out_head_valid),
    .out_total_count(out_total_count),
    .out_level_count(out_level_count),
    .out_is_empty(out_is_empty),
    .out_status(out_status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_top_level(cfg_top_level)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(6, 30));
  endfunction

  function automatic logic [mlpq_pkg::ID_W-1:0] rand_id();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 8) return '0;
    if (r < 16) return '1;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [1:0] rand_op();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 45) return mlpq_pkg::OP_ENQ;
    if (r < 80) return mlpq_pkg::OP_DEQ;
    if (r < 95) return mlpq_pkg::OP_PEEK;
    return OP_UNUSED;
  endfunction

  // called at a falling edge, returns at a falling edge with push still high
  task automatic send_word(input logic [1:0] op, input logic [mlpq_pkg::ID_W-1:0] tid,
                           input logic [mlpq_pkg::PR_W-1:0] pr);
    int gap;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push = 1'b1;
    in_op = op;
    in_task_id = tid;
    in_priority_req = pr;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_input(op, tid, pr);
    @(negedge clk);
  endtask

  task automatic drain();
    in_push = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_top(input logic [mlpq_pkg::PR_W-1:0] v);
    drain();
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_top_level = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_top(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_phase(input int n);
    int done;
    int mode;
    int k;
    logic [mlpq_pkg::PR_W-1:0] lvl;
    done = 0;
    while (done < n) begin
      mode = int'($urandom_range(0, 9));
      if (mode < 2) begin
        // hammer one level with a burst of enqueues, sometimes past its depth
        if ($urandom_range(0, 3) != 0) lvl = 3'($urandom_range(0, int'(sb.top_lvl)));
        else lvl = 3'($urandom_range(0, 7));
        k = int'($urandom_range(4, 18));
        repeat (k) send_word(mlpq_pkg::OP_ENQ, rand_id(), lvl);
        done += k;
      end else if (mode < 4) begin
        k = int'($urandom_range(4, 20));
        repeat (k) send_word(mlpq_pkg::OP_DEQ, rand_id(), 3'($urandom_range(0, 7)));
        done += k;
      end else begin
        send_word(rand_op(), rand_id(), 3'($urandom_range(0, 7)));
        done++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      got_word.head_task = out_head_task;
      got_word.head_priority = out_head_priority;
      got_word.head_valid = out_head_valid;
      got_word.total_count = out_total_count;
      got_word.level_count = out_level_count;
      got_word.is_empty = out_is_empty;
      got_word.status = out_status;
      sb.check_result(got_word);
    end
  end

  initial begin
    int gap;
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = pick_gap(recv_quiet);
      if (gap > 0) begin
        out_pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop = 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("multi_level_priority_queue verification failed");
    $finish;
  end

  initial begin
    logic [mlpq_pkg::PR_W-1:0] tops [10];
    rst_n = 1'b0;
    in_push = 1'b0;
    in_op = mlpq_pkg::OP_ENQ;
    in_task_id = '0;
    in_priority_req = '0;
    cfg_valid = 1'b0;
    cfg_top_level = 3'd7;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    sb = new();
    tops = '{3'd7, 3'd3, 3'd0, 3'd5, 3'd7, 3'd1, 3'd6, 3'd2, 3'd4, 3'd7};
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty cases, extremes, unknown op, full level, hidden levels
    send_word(mlpq_pkg::OP_PEEK, '0, 3'd0);
    send_word(mlpq_pkg::OP_DEQ, '0, 3'd0);
    send_word(mlpq_pkg::OP_ENQ, '1, 3'd7);
    send_word(OP_UNUSED, 16'h5a5a, 3'd7);
    for (int i = 0; i < DEPTH + 1; i++)
      send_word(mlpq_pkg::OP_ENQ, 16'(i * 16'h1111), 3'd2);
    send_word(mlpq_pkg::OP_DEQ, '0, 3'd7);
    write_top(3'd0);
    send_word(mlpq_pkg::OP_ENQ, 16'h00ff, 3'd1);
    send_word(mlpq_pkg::OP_PEEK, '0, 3'd2);
    send_word(mlpq_pkg::OP_DEQ, '0, 3'd2);

    for (int p = 0; p < 10; p++) begin
      write_top(p == 8 ? 3'($urandom_range(0, 7)) : tops[p]);
      send_quiet = (p % 4 == 1);
      recv_quiet = (p % 4 == 1) || (p % 4 == 3);
      run_phase(100);
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("multi_level_priority_queue verification clean");
    end else begin
      $display("multi_level_priority_queue verification failed");
    end
    $finish;
  end

endmodule
